// ----- rtl/dda_grid_ray_cast_core_macros.svh -----
// ----------------------------------------------------------------------------
// DDA ray cast core assertion macros
// Clocked assertion helpers shared by the ray cast RTL.
// ----------------------------------------------------------------------------
`ifndef DDA_GRID_RAY_CAST_CORE_MACROS_SVH
`define DDA_GRID_RAY_CAST_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DDA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dda assertion failed");
`define DDA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dda assertion failed");
`else
`define DDA_ASSERT(lbl, prop)
`define DDA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/dda_pkg.sv -----
// ----------------------------------------------------------------------------
// DDA ray cast package
// Shared constants, register indexes and divider request type.
// ----------------------------------------------------------------------------
package dda_pkg;
    localparam int MAP_WIDTH_DEF  = 32;
    localparam int MAP_HEIGHT_DEF = 32;
    localparam int MAX_COLUMNS    = 1024;
    localparam int FRAC_BITS      = 16;
    localparam int COORD_W        = 10;
    localparam int ACC_W          = 40;
    localparam int DIV_NW         = 33;
    localparam int DIV_DW         = 20;
    localparam int DIV_CW         = 6;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_COLUMNS = 3'd6;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } t_div_req;
endpackage

// ----- rtl/dda_grid_ray_cast_core.sv -----
// Load transaction: no result.
// Cast transaction: setup of three divisions on the shared serial divider and
// four products on the shared multiplier, then per map cell walked a step,
// bound check and map read, then an output state. One cast in flight.
// Reset is synchronous; afterwards a clearing pass writes zero to all
// MAP_WIDTH*MAP_HEIGHT map cells while s_axis_tready stays low.
// ----------------------------------------------------------------------------
// DDA grid ray cast core
// Grid map store and DDA ray walker on a shared divider and multiplier.
// ----------------------------------------------------------------------------
`include "dda_grid_ray_cast_core_macros.svh"
module dda_grid_ray_cast_core
    import dda_pkg::*;
#(
    parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cell_x[4:0], cell_y[9:5], cell_value[17:10], column[27:18]
    input  logic [31:0] s_axis_tdata,
    // mode[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // hit_wall[0], left_map[1], side_hit[2], perp_dist[33:3], hit_cell_x[38:34],
    // hit_cell_y[43:39], hit_value[51:44], ray_dir_x[71:52], ray_dir_y[91:72]
    output logic [95:0] m_axis_tdata
);
    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [ACC_W-1:0] DIST_MAX = ACC_W'(32'h7FFF_FFFF);
    localparam logic [16:0] ONE = 17'(1 << FRAC_BITS);

    typedef enum logic [14:0] {
        S_CLEAR = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_CAM   = 15'b000000000000100,
        S_MULX  = 15'b000000000001000,
        S_MULY  = 15'b000000000010000,
        S_RAYY  = 15'b000000000100000,
        S_DIVX  = 15'b000000001000000,
        S_DIVY  = 15'b000000010000000,
        S_MULSX = 15'b000000100000000,
        S_MULSY = 15'b000001000000000,
        S_SETSY = 15'b000010000000000,
        S_STEP  = 15'b000100000000000,
        S_BOUND = 15'b001000000000000,
        S_READ  = 15'b010000000000000,
        S_OUT   = 15'b100000000000000
    } t_state;

    t_state r_state;
    logic [AW:0] r_clr;

    logic [20:0] r_pos_x, r_pos_y;
    logic signed [18:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [10:0] r_cols;

    logic signed [28:0] r_cam;
    logic signed [19:0] r_rdx, r_rdy;
    logic [ACC_W-1:0] r_dx, r_dy, r_sx, r_sy;
    logic signed [COORD_W-1:0] r_mx, r_my;
    logic r_negx, r_negy, r_side, r_hit, r_left;
    logic [7:0] r_hv;

    logic        r_out_valid;
    logic [95:0] r_out_data;

    t_div_req          w_div_req;
    logic              w_div_done;
    logic [DIV_NW-1:0] w_quot;
    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod;
    logic              w_ram_we, w_ram_re;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [7:0]        w_wdata, w_rdata;
    logic              w_in_acc;
    logic [10:0]       w_cols;
    logic              w_out;
    logic [ACC_W-1:0]  w_perp;
    logic [16:0]       w_fx, w_fy;

    function automatic logic signed [19:0] f_ray(logic signed [18:0] d,
                                                 logic signed [63:0] p);
        logic signed [33:0] v;
        v = 34'(d) + 34'($signed(p[47:16]));
        if (v < -34'sd524288) begin
            return -20'sd524288;
        end else if (v > 34'sd524287) begin
            return 20'sd524287;
        end
        return v[19:0];
    endfunction

    function automatic logic [DIV_DW-1:0] f_abs(logic signed [19:0] r);
        return r[19] ? DIV_DW'(-r) : DIV_DW'(r);
    endfunction

    function automatic logic [ACC_W-1:0] f_cap(logic [DIV_NW-1:0] q);
        return (q[DIV_NW-1:31] != '0) ? DIST_MAX : ACC_W'(q[30:0]);
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_cols = (r_cols == '0) ? 11'd1 :
                    (32'(r_cols) > MAX_COLUMNS) ? 11'(MAX_COLUMNS) : r_cols;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 21'd1081344;
            r_pos_y   <= 21'd1081344;
            r_dir_x   <= -19'sd65536;
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= 19'sd43253;
            r_cols    <= 11'd320;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_POS_X:   r_pos_x   <= i_cfg_data;
                REG_POS_Y:   r_pos_y   <= i_cfg_data;
                REG_DIR_X:   r_dir_x   <= i_cfg_data[18:0];
                REG_DIR_Y:   r_dir_y   <= i_cfg_data[18:0];
                REG_PLANE_X: r_plane_x <= i_cfg_data[18:0];
                REG_PLANE_Y: r_plane_y <= i_cfg_data[18:0];
                REG_COLUMNS: r_cols    <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // map store
    always_comb begin
        w_ram_we = 1'b0;
        w_waddr  = r_clr[AW-1:0];
        w_wdata  = '0;
        if (r_state == S_CLEAR) begin
            w_ram_we = 1'b1;
        end else if (w_in_acc && !s_axis_tuser) begin
            w_ram_we = (32'(s_axis_tdata[4:0]) < MAP_WIDTH) &&
                       (32'(s_axis_tdata[9:5]) < MAP_HEIGHT);
            w_waddr  = AW'(32'(s_axis_tdata[4:0]) * MAP_HEIGHT +
                           32'(s_axis_tdata[9:5]));
            w_wdata  = s_axis_tdata[17:10];
        end
    end

    assign w_out = (r_mx < 0) || (r_mx >= $signed(COORD_W'(MAP_WIDTH))) ||
                   (r_my < 0) || (r_my >= $signed(COORD_W'(MAP_HEIGHT)));
    assign w_ram_re = (r_state == S_BOUND) && !w_out;
    assign w_raddr  = AW'(32'(r_mx) * MAP_HEIGHT + 32'(r_my));

    dda_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_map (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_ram_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // divider requests
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = DIV_NW'(s_axis_tdata[27:18]) << (FRAC_BITS + 1);
        w_div_req.divisor  = DIV_DW'(w_cols);
        if (r_state == S_IDLE) begin
            w_div_req.start = w_in_acc && s_axis_tuser;
        end else if (r_state == S_RAYY) begin
            w_div_req.start    = 1'b1;
            w_div_req.dividend = DIV_NW'(1) << (2 * FRAC_BITS);
            w_div_req.divisor  = f_abs(r_rdx);
        end else if (r_state == S_DIVX) begin
            w_div_req.start    = w_div_done;
            w_div_req.dividend = DIV_NW'(1) << (2 * FRAC_BITS);
            w_div_req.divisor  = f_abs(r_rdy);
        end
    end

    dda_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // multiplier operands
    assign w_fx = r_negx ? {1'b0, r_pos_x[15:0]} : ONE - {1'b0, r_pos_x[15:0]};
    assign w_fy = r_negy ? {1'b0, r_pos_y[15:0]} : ONE - {1'b0, r_pos_y[15:0]};

    always_comb begin
        w_mul_a = 32'(r_plane_x);
        w_mul_b = 32'(r_cam);
        case (r_state)
            S_MULY: begin
                w_mul_a = 32'(r_plane_y);
            end
            S_MULSX: begin
                w_mul_a = $signed(32'(w_fx));
                w_mul_b = $signed({1'b0, r_dx[30:0]});
            end
            S_MULSY: begin
                w_mul_a = $signed(32'(w_fy));
                w_mul_b = $signed({1'b0, r_dy[30:0]});
            end
            default: ;
        endcase
    end

    dda_mul u_mul (
        .i_clk(i_clk),
        .i_a  (w_mul_a),
        .i_b  (w_mul_b),
        .o_p  (w_prod)
    );

    assign w_perp = r_side ? (r_sy - r_dy) : (r_sx - r_dx);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc && s_axis_tuser) begin
                        r_state <= S_CAM;
                    end
                end
                S_CAM:   if (w_div_done) r_state <= S_MULX;
                S_MULX:  r_state <= S_MULY;
                S_MULY:  r_state <= S_RAYY;
                S_RAYY:  r_state <= S_DIVX;
                S_DIVX:  if (w_div_done) r_state <= S_DIVY;
                S_DIVY:  if (w_div_done) r_state <= S_MULSX;
                S_MULSX: r_state <= S_MULSY;
                S_MULSY: r_state <= S_SETSY;
                S_SETSY: r_state <= S_STEP;
                S_STEP:  r_state <= S_BOUND;
                S_BOUND: r_state <= w_out ? S_OUT : S_READ;
                S_READ:  r_state <= (w_rdata != '0) ? S_OUT : S_STEP;
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_hit  <= 1'b0;
                r_left <= 1'b0;
                r_hv   <= '0;
            end
            S_CAM: begin
                if (w_div_done) begin
                    r_cam <= 29'(w_quot[27:0]) - 29'(ONE);
                end
            end
            S_MULY: begin
                r_rdx  <= f_ray(r_dir_x, w_prod);
                r_negx <= f_ray(r_dir_x, w_prod) < 0;
            end
            S_RAYY: begin
                r_rdy  <= f_ray(r_dir_y, w_prod);
                r_negy <= f_ray(r_dir_y, w_prod) < 0;
            end
            S_DIVX: if (w_div_done) r_dx <= f_cap(w_quot);
            S_DIVY: if (w_div_done) r_dy <= f_cap(w_quot);
            S_MULSX: begin
                r_mx <= $signed(COORD_W'(r_pos_x[20:16]));
                r_my <= $signed(COORD_W'(r_pos_y[20:16]));
            end
            S_MULSY: r_sx <= ACC_W'(w_prod[47:16]);
            S_SETSY: r_sy <= ACC_W'(w_prod[47:16]);
            S_STEP: begin
                if (r_sx < r_sy) begin
                    r_sx   <= r_sx + r_dx;
                    r_mx   <= r_negx ? r_mx - 1'b1 : r_mx + 1'b1;
                    r_side <= 1'b0;
                end else begin
                    r_sy   <= r_sy + r_dy;
                    r_my   <= r_negy ? r_my - 1'b1 : r_my + 1'b1;
                    r_side <= 1'b1;
                end
            end
            S_BOUND: r_left <= w_out;
            S_READ: begin
                r_hit <= (w_rdata != '0);
                r_hv  <= w_rdata;
            end
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_data <= {4'b0, r_rdy, r_rdx, r_hv,
                                   r_hit ? r_my[4:0] : 5'd0,
                                   r_hit ? r_mx[4:0] : 5'd0,
                                   (w_perp > DIST_MAX) ? DIST_MAX[30:0] : w_perp[30:0],
                                   r_side, r_left, r_hit};
                end
            end
            default: ;
        endcase
    end

    `DDA_ASSERT(a_no_hit_and_left, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    `DDA_ASSERT(a_left_clears_cell, (m_axis_tvalid && m_axis_tdata[1]) |-> (m_axis_tdata[51:34] == '0))
    `DDA_ASSERT(a_clear_blocks_input, (r_state == S_CLEAR) |-> !s_axis_tready)
    `DDA_ASSERT_NEXT(a_read_follows_bound, (r_state == S_BOUND) && !w_out, r_state == S_READ)
endmodule

// ----- rtl/dda_ram.sv -----
// ----------------------------------------------------------------------------
// DDA generic RAM
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- rtl/dda_div.sv -----
// ----------------------------------------------------------------------------
// DDA serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dda_div
    import dda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quot
);
    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW:0]   w_sh;
    logic              w_ge;

    assign w_sh   = {r_rem, r_q[DIV_NW-1]};
    assign w_ge   = w_sh >= {1'b0, r_div};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            o_done <= 1'b0;
            r_cnt  <= DIV_CW'(DIV_NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end else begin
            o_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIV_DW'(w_sh - {1'b0, r_div}) : w_sh[DIV_DW-1:0];
            r_q   <= {r_q[DIV_NW-2:0], w_ge};
        end
    end
endmodule

// ----- rtl/dda_mul.sv -----
// ----------------------------------------------------------------------------
// DDA shared multiplier
// Signed 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module dda_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end
endmodule

// ----- test/dda_grid_ray_cast_core_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DDA ray cast result checker
// Watches the register port and both streams of the ray cast core, keeps its
// own map, registers and cast arithmetic, and compares every output
// transaction field by field with the oldest predicted cast result.
// ----------------------------------------------------------------------------
module dda_grid_ray_cast_core_check
    import dda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,
    output int          o_errors,
    output int          o_pending
);
    localparam longint DIST_CAP = 64'h7FFF_FFFF;
    localparam longint ONE      = 64'h1_0000;

    typedef struct packed {
        logic [19:0] ray_y;
        logic [19:0] ray_x;
        logic [7:0]  value;
        logic [4:0]  cy;
        logic [4:0]  cx;
        logic [30:0] perp;
        logic        side;
        logic        left;
        logic        hit;
    } t_cast;

    logic [7:0]  grid [0:1023];
    logic [20:0] r_pos_x, r_pos_y;
    logic [18:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [10:0] r_cols;
    t_cast       cast_q [$];

    function automatic longint ray_comp(logic [18:0] d, logic [18:0] p, longint cam);
        longint v;
        v = longint'($signed(d)) + ((longint'($signed(p)) * cam) >>> FRAC_BITS);
        if (v < -(64'sd1 <<< 19)) v = -(64'sd1 <<< 19);
        if (v > (64'sd1 <<< 19) - 1) v = (64'sd1 <<< 19) - 1;
        return v;
    endfunction

    function automatic longint step_len(longint r);
        longint a, q;
        a = (r < 0) ? -r : r;
        if (a == 0) return DIST_CAP;
        q = (64'sd1 <<< 32) / a;
        return (q > DIST_CAP) ? DIST_CAP : q;
    endfunction

    function automatic t_cast cast_ray(logic [9:0] col);
        t_cast  res;
        longint cols, cam, rdx, rdy, dx, dy, sx, sy, fx, fy, mx, my, stx, sty, perp;
        logic   done;
        res  = '0;
        cols = r_cols;
        if (cols == 0) cols = 1;
        if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
        cam = ((longint'(col) <<< (FRAC_BITS + 1)) / cols) - ONE;
        rdx = ray_comp(r_dir_x, r_plane_x, cam);
        rdy = ray_comp(r_dir_y, r_plane_y, cam);
        dx  = step_len(rdx);
        dy  = step_len(rdy);
        mx  = r_pos_x >> FRAC_BITS;
        my  = r_pos_y >> FRAC_BITS;
        fx  = r_pos_x & (ONE - 1);
        fy  = r_pos_y & (ONE - 1);
        if (rdx < 0) begin
            stx = -1; sx = (fx * dx) >>> FRAC_BITS;
        end else begin
            stx = 1;  sx = ((ONE - fx) * dx) >>> FRAC_BITS;
        end
        if (rdy < 0) begin
            sty = -1; sy = (fy * dy) >>> FRAC_BITS;
        end else begin
            sty = 1;  sy = ((ONE - fy) * dy) >>> FRAC_BITS;
        end
        done = 1'b0;
        while (!done) begin
            if (sx < sy) begin
                sx += dx; mx += stx; res.side = 1'b0;
            end else begin
                sy += dy; my += sty; res.side = 1'b1;
            end
            if (mx < 0 || mx >= MAP_WIDTH_DEF || my < 0 || my >= MAP_HEIGHT_DEF) begin
                res.left = 1'b1;
                done = 1'b1;
            end else if (grid[mx * MAP_HEIGHT_DEF + my] != 8'd0) begin
                res.hit   = 1'b1;
                res.cx    = mx[4:0];
                res.cy    = my[4:0];
                res.value = grid[mx * MAP_HEIGHT_DEF + my];
                done = 1'b1;
            end
        end
        perp = res.side ? sy - dy : sx - dx;
        if (perp > DIST_CAP) perp = DIST_CAP;
        res.perp  = perp[30:0];
        res.ray_x = rdx[19:0];
        res.ray_y = rdy[19:0];
        return res;
    endfunction

    task automatic field_cmp(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
                     exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cast exp_r, act_r;
        if (!i_rst_n) begin
            for (int k = 0; k < 1024; k++) grid[k] = 8'd0;
            r_pos_x   = 21'd1081344;
            r_pos_y   = 21'd1081344;
            r_dir_x   = -19'sd65536;
            r_dir_y   = '0;
            r_plane_x = '0;
            r_plane_y = 19'd43253;
            r_cols    = 11'd320;
            cast_q.delete();
            o_errors  = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_POS_X:   r_pos_x   = i_cfg_data;
                    REG_POS_Y:   r_pos_y   = i_cfg_data;
                    REG_DIR_X:   r_dir_x   = i_cfg_data[18:0];
                    REG_DIR_Y:   r_dir_y   = i_cfg_data[18:0];
                    REG_PLANE_X: r_plane_x = i_cfg_data[18:0];
                    REG_PLANE_Y: r_plane_y = i_cfg_data[18:0];
                    REG_COLUMNS: r_cols    = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                act_r = i_m_tdata[91:0];
                if (cast_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h", $time,
                             i_m_tdata);
                    o_errors++;
                end else begin
                    exp_r = cast_q.pop_front();
                    field_cmp("hit_wall", exp_r.hit, act_r.hit);
                    field_cmp("left_map", exp_r.left, act_r.left);
                    field_cmp("side_hit", exp_r.side, act_r.side);
                    field_cmp("perp_dist", exp_r.perp, act_r.perp);
                    field_cmp("hit_cell_x", exp_r.cx, act_r.cx);
                    field_cmp("hit_cell_y", exp_r.cy, act_r.cy);
                    field_cmp("hit_value", exp_r.value, act_r.value);
                    field_cmp("ray_dir_x", exp_r.ray_x, act_r.ray_x);
                    field_cmp("ray_dir_y", exp_r.ray_y, act_r.ray_y);
                    field_cmp("pad", 0, i_m_tdata[95:92]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser)
                    cast_q.push_back(cast_ray(i_s_tdata[27:18]));
                else
                    grid[i_s_tdata[4:0] * MAP_HEIGHT_DEF + i_s_tdata[9:5]] = i_s_tdata[17:10];
            end
        end
        o_pending = cast_q.size();
    end
endmodule

// ----- test/dda_grid_ray_cast_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DDA ray cast core testbench
// Drives map loads and column casts through phases of register settings,
// with random idle cycles on both streams, a long output hold-off and idle
// pauses between phases; the checker module predicts and compares results.
// ----------------------------------------------------------------------------
module dda_grid_ray_cast_core_test;
    import dda_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [20:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    int          errors, pending;
    logic        burst = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    logic [20:0] cfg_val [0:7];

    dda_grid_ray_cast_core u_top (.*);

    dda_grid_ray_cast_core_check u_check (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_data,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .o_errors(errors), .o_pending(pending)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int idle_len();
        return burst ? 0 : $urandom_range(0, 17);
    endfunction

    // output side: random idles, one long hold-off on request
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                gap = idle_len();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_item(logic cast, logic [4:0] cx, logic [4:0] cy,
                             logic [7:0] val, logic [9:0] col);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cast;
        s_axis_tdata  <= {4'd0, col, val, cy, cx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic rand_item(int cast_pct);
        send_item($urandom_range(0, 99) < cast_pct, 5'($urandom), 5'($urandom),
                  ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom), 10'($urandom));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs();
        for (int k = 0; k < 8; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= 3'(k);
            i_cfg_data  <= cfg_val[k];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [20:0] sgn_val(int v);
        return {2'($urandom), 19'(v)};
    endfunction

    initial begin
        int lo, hi;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset: corners, erased cell, edge columns
        send_item(1'b0, 5'd0, 5'd0, 8'd255, 10'd0);
        send_item(1'b0, 5'd31, 5'd31, 8'd1, 10'd1023);
        send_item(1'b0, 5'd0, 5'd31, 8'd128, 10'd0);
        send_item(1'b0, 5'd31, 5'd0, 8'd7, 10'd0);
        send_item(1'b0, 5'd31, 5'd31, 8'd0, 10'd0);
        send_item(1'b1, 5'd0, 5'd0, 8'd0, 10'd0);
        send_item(1'b1, 5'd31, 5'd31, 8'd255, 10'd1023);
        send_item(1'b1, 5'd0, 5'd0, 8'd0, 10'd160);
        send_item(1'b1, 5'd0, 5'd0, 8'd0, 10'd319);
        send_item(1'b1, 5'd0, 5'd0, 8'd0, 10'd320);
        for (int k = 0; k < 32; k += 3) send_item(1'b0, 5'd2, 5'(k), 8'd9, 10'd0);
        send_item(1'b1, 5'd0, 5'd0, 8'd0, 10'd100);
        send_item(1'b1, 5'd0, 5'd0, 8'd0, 10'd200);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: begin
                    cfg_val = '{21'd0, 21'd0, sgn_val(-131072), sgn_val(-131072),
                                sgn_val(-131072), sgn_val(-131072), 21'd0, 21'h1FFFFF};
                end
                1: begin
                    cfg_val = '{21'h1FFFFF, 21'h1FFFFF, sgn_val(131072), sgn_val(131072),
                                sgn_val(131072), sgn_val(131072), 21'h1FF7FF, 21'd0};
                end
                2: begin
                    cfg_val = '{21'd1081344, 21'd600000, sgn_val(0), sgn_val(0),
                                sgn_val(0), sgn_val(0), 21'd1, 21'd5};
                end
                default: begin
                    cfg_val[0] = 21'($urandom_range(0, 21'h1FFFFF));
                    cfg_val[1] = 21'($urandom_range(0, 21'h1FFFFF));
                    for (int k = 2; k < 6; k++)
                        cfg_val[k] = sgn_val($urandom_range(0, 262144) - 131072);
                    cfg_val[6] = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(0, 2047))
                                                             : 21'($urandom_range(1, 1024));
                    cfg_val[7] = 21'($urandom);
                end
            endcase
            write_regs();
            burst = (ph % 3 == 1);
            if (ph == 4) hold_req = 1'b1;
            // walls first so later casts hit more often
            lo = 40; hi = 60;
            for (int n = 0; n < $urandom_range(lo, hi); n++) rand_item(0);
            for (int n = 0; n < 70; n++) rand_item(70);
        end

        settle();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
